FILE: src/emru_pkg.sv
// ----------------------------------------------------------------------------
// emru_pkg: shared widths, types and rounding helpers
// Fixed-point widths of the reflection texture coordinate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package emru_pkg;

    localparam int POS_W   = 24;              // position width
    localparam int NRM_W   = 16;              // Q1.14 normal
    localparam int CF_W    = 16;              // Q2.13 coefficient
    localparam int ROW_W   = 3 * CF_W;        // one matrix row register
    localparam int MP_W    = NRM_W + CF_W;    // one normal by coefficient product
    localparam int ACC_W   = MP_W + 2;        // sum of three products
    localparam int T_W     = ACC_W - 13;      // transformed normal, Q.14
    localparam int PROD_W  = T_W + POS_W;
    localparam int DSUM_W  = PROD_W + 2;
    localparam int D_W     = DSUM_W - 14 + 1;
    localparam int DT_W    = D_W + T_W;
    localparam int R_W     = DT_W + 2;        // reflected component, signed
    localparam int IDX_W   = $clog2(R_W);
    localparam int NM_W    = 30;              // normalized magnitude
    localparam int SQ_W    = 2 * NM_W;
    localparam int RAD_W   = SQ_W + 2;        // sum of three squares
    localparam int LEN_W   = RAD_W / 2;       // floor square root
    localparam int Q_W     = 16;              // quotient of one coordinate
    localparam int UV_W    = 16;
    localparam logic [UV_W-1:0] HALF_UV = 16'h8000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_2000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_2000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h2000_0000_0000;

    typedef struct packed {
        logic [NM_W-1:0] mag_x;
        logic [NM_W-1:0] mag_y;
        logic            neg_x;
        logic            neg_y;
        logic            degen;
    } side_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic degen;
    } flags_t;

    // Round a three-product sum by 13 bits, halves away from zero.
    function automatic logic signed [T_W-1:0] round_acc(input logic signed [ACC_W-1:0] x);
        logic [ACC_W:0] m;
        logic [ACC_W:0] r;
        m = x[ACC_W-1] ? -{x[ACC_W-1], x} : {1'b0, x};
        r = (m + (ACC_W+1)'(4096)) >> 13;
        return x[ACC_W-1] ? -T_W'(r) : T_W'(r);
    endfunction

    // Round the dot product by 14 bits, halves away from zero.
    function automatic logic signed [D_W-1:0] round_dot(input logic signed [DSUM_W-1:0] x);
        logic [DSUM_W:0] m;
        logic [DSUM_W:0] r;
        m = x[DSUM_W-1] ? -{x[DSUM_W-1], x} : {1'b0, x};
        r = (m + (DSUM_W+1)'(8192)) >> 14;
        return x[DSUM_W-1] ? -D_W'(r) : D_W'(r);
    endfunction

endpackage
`default_nettype wire

FILE: src/env_map_reflection_uv_core.sv
// ----------------------------------------------------------------------------
// env_map_reflection_uv_core: sphere environment map texture coordinates
// Transforms the normal, reflects the position about it, normalizes the
// reflection and maps x and y to Q0.16 texture coordinates.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  input    | s_valid / s_ready    | s_pos_x/y/z, s_norm_x/y/z
//  result   | m_valid / m_ready    | m_u_coord, m_v_coord, m_degenerate
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word enters per cycle while s_ready is high; the pipeline has 12 arithmetic
// stages, 31 square root stages, 16 divider stages and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall holds every stage in place.
// Reset is synchronous, clears the valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none
module env_map_reflection_uv_core (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [emru_pkg::POS_W-1:0]       s_pos_x,
    input  wire logic signed [emru_pkg::POS_W-1:0]       s_pos_y,
    input  wire logic signed [emru_pkg::POS_W-1:0]       s_pos_z,
    input  wire logic signed [emru_pkg::NRM_W-1:0]       s_norm_x,
    input  wire logic signed [emru_pkg::NRM_W-1:0]       s_norm_y,
    input  wire logic signed [emru_pkg::NRM_W-1:0]       s_norm_z,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [emru_pkg::UV_W-1:0]                    m_u_coord,
    output logic [emru_pkg::UV_W-1:0]                    m_v_coord,
    output logic                                         m_degenerate,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [emru_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [emru_pkg::ROW_W-1:0]              cfg_data
);
    localparam int POS_W  = emru_pkg::POS_W;
    localparam int NRM_W  = emru_pkg::NRM_W;
    localparam int CF_W   = emru_pkg::CF_W;
    localparam int MP_W   = emru_pkg::MP_W;
    localparam int ACC_W  = emru_pkg::ACC_W;
    localparam int T_W    = emru_pkg::T_W;
    localparam int PROD_W = emru_pkg::PROD_W;
    localparam int DSUM_W = emru_pkg::DSUM_W;
    localparam int D_W    = emru_pkg::D_W;
    localparam int DT_W   = emru_pkg::DT_W;
    localparam int R_W    = emru_pkg::R_W;
    localparam int IDX_W  = emru_pkg::IDX_W;
    localparam int NM_W   = emru_pkg::NM_W;
    localparam int SQ_W   = emru_pkg::SQ_W;
    localparam int RAD_W  = emru_pkg::RAD_W;
    localparam int NV     = 12;

    logic en;
    logic [emru_pkg::ROW_W-1:0] row_reg [3];
    logic [NV-1:0] v_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= emru_pkg::ROW_X_RST;
            row_reg[1] <= emru_pkg::ROW_Y_RST;
            row_reg[2] <= emru_pkg::ROW_Z_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                emru_pkg::REG_ROW_X: row_reg[0] <= cfg_data;
                emru_pkg::REG_ROW_Y: row_reg[1] <= cfg_data;
                emru_pkg::REG_ROW_Z: row_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NV-2:0], s_valid};
        end
    end

    // Stage 1: input registers.
    logic signed [POS_W-1:0] p1_reg [3];
    logic signed [NRM_W-1:0] n1_reg [3];
    // Stage 2: nine normal by coefficient products, [input axis][output axis].
    logic signed [MP_W-1:0]  mp2_reg [3][3];
    logic signed [POS_W-1:0] p2_reg [3];
    // Stage 3: transformed normal.
    logic signed [T_W-1:0]   t3_reg [3];
    logic signed [POS_W-1:0] p3_reg [3];
    // Stage 4: dot product terms.
    logic signed [PROD_W-1:0] tp4_reg [3];
    logic signed [T_W-1:0]    t4_reg [3];
    logic signed [POS_W-1:0]  p4_reg [3];
    // Stage 5: rounded dot product.
    logic signed [D_W-1:0]    d5_reg;
    logic signed [T_W-1:0]    t5_reg [3];
    logic signed [POS_W-1:0]  p5_reg [3];
    // Stage 6: d times t.
    logic signed [DT_W-1:0]   dt6_reg [3];
    logic signed [POS_W-1:0]  p6_reg [3];
    // Stage 7: reflection magnitudes and signs.
    logic [R_W-1:0]           mag7_reg [3];
    logic [1:0]               neg7_reg;
    // Stage 8: largest magnitude.
    logic [R_W-1:0]           mag8_reg [3];
    logic [R_W-1:0]           max8_reg;
    logic [1:0]               neg8_reg;
    // Stage 9: leading one position.
    logic [R_W-1:0]           mag9_reg [3];
    logic [IDX_W-1:0]         k9_reg;
    logic                     z9_reg;
    logic [1:0]               neg9_reg;
    // Stage 10: normalized magnitudes.
    logic [NM_W-1:0]          nm10_reg [3];
    logic                     z10_reg;
    logic [1:0]               neg10_reg;
    // Stage 11: squares.
    logic [SQ_W-1:0]          sq11_reg [3];
    emru_pkg::side_t          side11_reg;
    // Stage 12: sum of squares.
    logic [RAD_W-1:0]         rad12_reg;
    emru_pkg::side_t          side12_reg;

    logic signed [ACC_W-1:0]  acc_c [3];
    logic signed [DSUM_W-1:0] dsum_c;
    logic [R_W-1:0]           max_c;
    logic [IDX_W-1:0]         k_c;
    logic [NM_W-1:0]          nm_c [3];
    logic signed [R_W-1:0]    r_c [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_c[a] = ACC_W'(mp2_reg[0][a]) + ACC_W'(mp2_reg[1][a]) + ACC_W'(mp2_reg[2][a]);
            r_c[a]   = (R_W'(p6_reg[a]) <<< 14) - (R_W'(dt6_reg[a]) <<< 1);
        end
        dsum_c = DSUM_W'(tp4_reg[0]) + DSUM_W'(tp4_reg[1]) + DSUM_W'(tp4_reg[2]);
        max_c  = mag7_reg[0];
        if (mag7_reg[1] > max_c) max_c = mag7_reg[1];
        if (mag7_reg[2] > max_c) max_c = mag7_reg[2];
        k_c = '0;
        for (int i = 0; i < R_W; i++) begin
            if (max8_reg[i]) k_c = IDX_W'(i);
        end
        // Bring the leading one of the largest magnitude to bit 29.
        for (int a = 0; a < 3; a++) begin
            if (k9_reg >= IDX_W'(NM_W - 1)) begin
                nm_c[a] = NM_W'(mag9_reg[a] >> (k9_reg - IDX_W'(NM_W - 1)));
            end else begin
                nm_c[a] = NM_W'(mag9_reg[a] << (IDX_W'(NM_W - 1) - k9_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= '{s_pos_x, s_pos_y, s_pos_z};
            n1_reg <= '{s_norm_x, s_norm_y, s_norm_z};
            for (int i = 0; i < 3; i++) begin
                for (int a = 0; a < 3; a++) begin
                    mp2_reg[i][a] <= MP_W'(n1_reg[i] * $signed(row_reg[i][CF_W*a +: CF_W]));
                end
            end
            p2_reg <= p1_reg;
            for (int a = 0; a < 3; a++) begin
                t3_reg[a]  <= emru_pkg::round_acc(acc_c[a]);
                tp4_reg[a] <= PROD_W'(t3_reg[a] * p3_reg[a]);
                dt6_reg[a] <= DT_W'(d5_reg * t5_reg[a]);
                mag7_reg[a] <= r_c[a][R_W-1] ? R_W'(-r_c[a]) : R_W'(r_c[a]);
                sq11_reg[a] <= SQ_W'(nm10_reg[a] * nm10_reg[a]);
            end
            p3_reg <= p2_reg;
            t4_reg <= t3_reg;
            p4_reg <= p3_reg;
            d5_reg <= emru_pkg::round_dot(dsum_c);
            t5_reg <= t4_reg;
            p5_reg <= p4_reg;
            p6_reg <= p5_reg;
            neg7_reg <= {r_c[1][R_W-1], r_c[0][R_W-1]};
            mag8_reg <= mag7_reg;
            max8_reg <= max_c;
            neg8_reg <= neg7_reg;
            mag9_reg <= mag8_reg;
            k9_reg   <= k_c;
            z9_reg   <= (max8_reg == '0);
            neg9_reg <= neg8_reg;
            nm10_reg  <= nm_c;
            z10_reg   <= z9_reg;
            neg10_reg <= neg9_reg;
            side11_reg <= '{mag_x: nm10_reg[0], mag_y: nm10_reg[1],
                            neg_x: neg10_reg[0], neg_y: neg10_reg[1], degen: z10_reg};
            rad12_reg  <= RAD_W'(sq11_reg[0]) + RAD_W'(sq11_reg[1]) + RAD_W'(sq11_reg[2]);
            side12_reg <= side11_reg;
        end
    end

    logic                          sq_valid;
    logic [emru_pkg::LEN_W-1:0]    sq_len;
    emru_pkg::side_t               sq_side;
    logic                          dv_valid;
    logic [emru_pkg::Q_W-1:0]      dv_qx, dv_qy;
    emru_pkg::flags_t              dv_flags;

    emru_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[NV-1]),
        .radicand  (rad12_reg),
        .side_in   (side12_reg),
        .out_valid (sq_valid),
        .len       (sq_len),
        .side_out  (sq_side)
    );

    emru_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .len       (sq_len),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .q_x       (dv_qx),
        .q_y       (dv_qy),
        .flags_out (dv_flags)
    );

    // The quotient never exceeds one half, so only the top edge saturates.
    function automatic logic [emru_pkg::UV_W-1:0] to_coord(input logic [emru_pkg::Q_W-1:0] q,
                                                          input logic neg);
        logic [emru_pkg::UV_W:0] c;
        if (neg) begin
            c = {1'b0, emru_pkg::HALF_UV} - (emru_pkg::UV_W+1)'(q);
        end else begin
            c = {1'b0, emru_pkg::HALF_UV} + (emru_pkg::UV_W+1)'(q);
        end
        return c[emru_pkg::UV_W] ? '1 : c[emru_pkg::UV_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_degenerate <= dv_flags.degen;
            if (dv_flags.degen) begin
                m_u_coord <= emru_pkg::HALF_UV;
                m_v_coord <= emru_pkg::HALF_UV;
            end else begin
                m_u_coord <= to_coord(dv_qx, dv_flags.neg_x);
                m_v_coord <= to_coord(dv_qy, dv_flags.neg_y);
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/emru_sqrt.sv
// ----------------------------------------------------------------------------
// emru_sqrt: pipelined integer square root
// One result bit per stage, floor of the square root, side data carried along.
// ----------------------------------------------------------------------------
`default_nettype none
module emru_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [emru_pkg::RAD_W-1:0]    radicand,
    input  wire emru_pkg::side_t               side_in,
    output logic                               out_valid,
    output logic [emru_pkg::LEN_W-1:0]         len,
    output emru_pkg::side_t                    side_out
);
    localparam int N  = emru_pkg::LEN_W;
    localparam int RW = emru_pkg::RAD_W + 2;

    logic [RW-1:0]               rem_reg  [N];
    logic [emru_pkg::LEN_W-1:0]  root_reg [N];
    logic                        vld_reg  [N];
    emru_pkg::side_t             side_reg [N];

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            localparam int I = N - 1 - s;
            logic [RW-1:0]              rem_in;
            logic [emru_pkg::LEN_W-1:0] root_in;
            logic                       vld_in;
            emru_pkg::side_t            side_i;
            logic [RW-1:0]              trial;
            if (s == 0) begin : g_first
                assign rem_in  = RW'(radicand);
                assign root_in = '0;
                assign vld_in  = in_valid;
                assign side_i  = side_in;
            end else begin : g_next
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign vld_in  = vld_reg[s-1];
                assign side_i  = side_reg[s-1];
            end
            // Remainder holds radicand minus root squared.
            assign trial = (RW'(root_in) << (I + 1)) + (RW'(1) << (2 * I));

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (en) begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[s] <= side_i;
                    if (rem_in >= trial) begin
                        rem_reg[s]  <= rem_in - trial;
                        root_reg[s] <= root_in | (emru_pkg::LEN_W'(1) << I);
                    end else begin
                        rem_reg[s]  <= rem_in;
                        root_reg[s] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign len       = root_reg[N-1];
    assign side_out  = side_reg[N-1];
endmodule
`default_nettype wire

FILE: src/emru_div.sv
// ----------------------------------------------------------------------------
// emru_div: pipelined two-lane rounding divider
// Computes round(mag * 32768 / len) for x and y, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module emru_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [emru_pkg::LEN_W-1:0]    len,
    input  wire emru_pkg::side_t               side_in,
    output logic                               out_valid,
    output logic [emru_pkg::Q_W-1:0]           q_x,
    output logic [emru_pkg::Q_W-1:0]           q_y,
    output emru_pkg::flags_t                   flags_out
);
    localparam int N  = emru_pkg::Q_W;
    localparam int NW = emru_pkg::NM_W + N + 1;   // numerator and remainder
    localparam int DW = emru_pkg::LEN_W + 1;      // divisor is twice the length

    logic [NW-1:0]          remx_reg [N];
    logic [NW-1:0]          remy_reg [N];
    logic [N-1:0]           qx_reg   [N];
    logic [N-1:0]           qy_reg   [N];
    logic [DW-1:0]          div_reg  [N];
    logic                   vld_reg  [N];
    emru_pkg::flags_t       flg_reg  [N];

    emru_pkg::flags_t       flg_first;
    assign flg_first = '{neg_x: side_in.neg_x, neg_y: side_in.neg_y, degen: side_in.degen};

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            localparam int J = N - 1 - s;
            logic [NW-1:0]     rx_in, ry_in, sub;
            logic [N-1:0]      qx_in, qy_in;
            logic [DW-1:0]     d_in;
            logic              vld_in;
            emru_pkg::flags_t  flg_in;
            if (s == 0) begin : g_first
                // Adding len before dividing by 2*len rounds halves up.
                assign rx_in  = {side_in.mag_x, N'(0)} + NW'(len);
                assign ry_in  = {side_in.mag_y, N'(0)} + NW'(len);
                assign qx_in  = '0;
                assign qy_in  = '0;
                assign d_in   = {len, 1'b0};
                assign vld_in = in_valid;
                assign flg_in = flg_first;
            end else begin : g_next
                assign rx_in  = remx_reg[s-1];
                assign ry_in  = remy_reg[s-1];
                assign qx_in  = qx_reg[s-1];
                assign qy_in  = qy_reg[s-1];
                assign d_in   = div_reg[s-1];
                assign vld_in = vld_reg[s-1];
                assign flg_in = flg_reg[s-1];
            end
            assign sub = NW'(d_in) << J;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (en) begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    div_reg[s] <= d_in;
                    flg_reg[s] <= flg_in;
                    if (rx_in >= sub) begin
                        remx_reg[s] <= rx_in - sub;
                        qx_reg[s]   <= qx_in | (N'(1) << J);
                    end else begin
                        remx_reg[s] <= rx_in;
                        qx_reg[s]   <= qx_in;
                    end
                    if (ry_in >= sub) begin
                        remy_reg[s] <= ry_in - sub;
                        qy_reg[s]   <= qy_in | (N'(1) << J);
                    end else begin
                        remy_reg[s] <= ry_in;
                        qy_reg[s]   <= qy_in;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign q_x       = qx_reg[N-1];
    assign q_y       = qy_reg[N-1];
    assign flags_out = flg_reg[N-1];
endmodule
`default_nettype wire
